// ===== sv/assert_macros.svh =====
// Assertion macros shared by the track speed check RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with synchronous active-low reset masking.
`define CHK_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Same, on the block clock and reset.
`define CHK_ASSERT_CLK(lbl, prop) `CHK_ASSERT(lbl, i_clk, i_rst_n, prop)

`endif

// ===== sv/trk_pkg.sv =====
// Shared types, constants and helper functions for the track speed check.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package trk_pkg;

    localparam int ANGLE_FRAC_BITS = 20;
    localparam int EARTH_RADIUS_M  = 6371000;

    localparam int LAT_W   = 28;
    localparam int LON_W   = 29;
    localparam int TIME_W  = 32;
    localparam int DIST_W  = 25;
    localparam int SPEED_W = 32;
    localparam int DLAT_W  = LAT_W + 1;
    localparam int DLON_W  = LON_W + 1;
    localparam int ANG_W   = DLON_W - 1;

    // CORDIC datapath
    localparam int CW           = 34;
    localparam int MUL_W        = 2 * CW;
    localparam int CORDIC_ITERS = 30;
    localparam int CNT_W        = 5;
    localparam int Q_FRAC       = 30;

    // Square root datapath
    localparam int SQ_W       = 62;
    localparam int SQRT_STEPS = 31;
    localparam int H_W        = Q_FRAC + 1;

    localparam logic [DLON_W-1:0] FULL_TURN = DLON_W'(360 << ANGLE_FRAC_BITS);
    localparam logic [DLON_W-1:0] HALF_TURN = DLON_W'(180 << ANGLE_FRAC_BITS);
    localparam logic [DLON_W-1:0] QUARTER   = DLON_W'(90 << ANGLE_FRAC_BITS);

    localparam logic signed [CW-1:0] GAIN_INV    = CW'(652032874);
    localparam logic signed [CW-1:0] DEG2RAD_Q32 = CW'(74961321);
    localparam logic signed [CW-1:0] TWO_RADIUS  = CW'(2 * EARTH_RADIUS_M);
    localparam logic [H_W-1:0]       Q30_ONE     = H_W'(1) << Q_FRAC;
    localparam logic [SQ_W-1:0]      SQ_BIT0     = SQ_W'(1) << (2 * (SQRT_STEPS - 1));
    localparam logic [MUL_W-1:0]     ROUND_HALF  = MUL_W'(1) << (Q_FRAC - 1);
    localparam logic [DIST_W-1:0]    DIST_MAX    = '1;
    localparam logic [SPEED_W-1:0]   SPEED_RESET = SPEED_W'(13107200);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic                     hp;
        logic                     first;
        logic                     last;
        logic signed [LAT_W-1:0]  lat1;
        logic signed [LAT_W-1:0]  lat2;
        logic signed [DLAT_W-1:0] dlat;
        logic signed [DLON_W-1:0] dlon;
        logic [TIME_W-1:0]        gap;
    } t_seg_cmd;

    typedef struct packed {
        logic             neg;
        logic [ANG_W-1:0] u;
    } t_red;

    function automatic logic signed [CW-1:0] atan_q30(input logic [CNT_W-1:0] idx);
        logic signed [CW-1:0] v;
        case (idx)
            5'd0:  v = CW'(32'h3243F6A8);
            5'd1:  v = CW'(32'h1DAC6705);
            5'd2:  v = CW'(32'h0FADBAFC);
            5'd3:  v = CW'(32'h07F56EA6);
            5'd4:  v = CW'(32'h03FEAB76);
            5'd5:  v = CW'(32'h01FFD55B);
            5'd6:  v = CW'(32'h00FFFAAA);
            5'd7:  v = CW'(32'h007FFF55);
            5'd8:  v = CW'(32'h003FFFEA);
            5'd9:  v = CW'(32'h001FFFFD);
            5'd10: v = CW'(32'h000FFFFF);
            5'd11: v = CW'(32'h0007FFFF);
            5'd12: v = CW'(32'h0003FFFF);
            5'd13: v = CW'(32'h0001FFFF);
            5'd14: v = CW'(32'h0000FFFF);
            5'd15: v = CW'(32'h00007FFF);
            5'd16: v = CW'(32'h00003FFF);
            5'd17: v = CW'(32'h00001FFF);
            5'd18: v = CW'(32'h00000FFF);
            5'd19: v = CW'(32'h000007FF);
            5'd20: v = CW'(32'h000003FF);
            5'd21: v = CW'(32'h000001FF);
            5'd22: v = CW'(32'h000000FF);
            5'd23: v = CW'(32'h0000007F);
            5'd24: v = CW'(32'h0000003F);
            5'd25: v = CW'(32'h0000001F);
            5'd26: v = CW'(32'h0000000F);
            5'd27: v = CW'(32'h00000008);
            5'd28: v = CW'(32'h00000004);
            5'd29: v = CW'(32'h00000002);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Fold an angle in degree units into [0, 180] (sine) or [0, 90] (cosine).
    function automatic t_red reduce_angle(input logic signed [DLON_W-1:0] d,
                                          input logic is_cos);
        logic [DLON_W-1:0] a;
        t_red r;
        a = d[DLON_W-1] ? DLON_W'(-d) : DLON_W'(d);
        if (a >= FULL_TURN) a = a - FULL_TURN;
        if (a > HALF_TURN) a = FULL_TURN - a;
        r.neg = 1'b0;
        if (is_cos && (a > QUARTER)) begin
            a = HALF_TURN - a;
            r.neg = 1'b1;
        end
        r.u = a[ANG_W-1:0];
        return r;
    endfunction

endpackage

// ===== sv/track_speed_plausibility_check_unit.sv =====
// Track speed plausibility check, top level: configuration register, front end,
// command queue and distance engine. Depends on trk_pkg, trk_front, trk_queue, trk_back.
`timescale 1ns / 1ps

// Takes the points of a path (latitude, longitude in degrees * 2^20, time in
// seconds) and gives one result per point: the haversine distance to the
// previous point in meters, whether that segment beats speed_limit (Q16.16 m/s)
// times the time gap, and a sticky suspect flag that is final on the last point.
// A point with no previous point skips the distance computation; any other one goes
// through the single shared CORDIC engine (four 30-step rotations and one 30-step
// arctangent) and the 31-step square root. A two-entry queue lets new points be
// taken while a segment is computed or a result waits.
module track_speed_plausibility_check_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [trk_pkg::LAT_W-1:0] i_latitude,
    input  logic signed [trk_pkg::LON_W-1:0] i_longitude,
    input  logic [trk_pkg::TIME_W-1:0]       i_timestamp,
    input  logic                             i_first_of_path,
    input  logic                             i_last_of_path,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [trk_pkg::DIST_W-1:0]       o_segment_distance,
    output logic                             o_segment_too_fast,
    output logic                             o_path_suspect,
    output logic                             o_verdict_valid,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [trk_pkg::SPEED_W-1:0]      i_cfg_data
);
    import trk_pkg::*;

    logic [SPEED_W-1:0] r_speed_limit;
    logic               push, pop, q_full, q_valid;
    t_seg_cmd           push_cmd, head_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_limit <= SPEED_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_speed_limit <= i_cfg_data;
        end
    end

    trk_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_latitude      (i_latitude),
        .i_longitude     (i_longitude),
        .i_timestamp     (i_timestamp),
        .i_first_of_path (i_first_of_path),
        .i_last_of_path  (i_last_of_path),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    trk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    trk_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_cmd              (head_cmd),
        .o_pop              (pop),
        .i_speed_limit      (r_speed_limit),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_segment_distance (o_segment_distance),
        .o_segment_too_fast (o_segment_too_fast),
        .o_path_suspect     (o_path_suspect),
        .o_verdict_valid    (o_verdict_valid)
    );

endmodule

// ===== sv/trk_front.sv =====
// Front end: accepts sighting points, keeps the previous point, builds segment commands.
// Depends on trk_pkg.
`timescale 1ns / 1ps

module trk_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [trk_pkg::LAT_W-1:0] i_latitude,
    input  logic signed [trk_pkg::LON_W-1:0] i_longitude,
    input  logic [trk_pkg::TIME_W-1:0]     i_timestamp,
    input  logic                           i_first_of_path,
    input  logic                           i_last_of_path,
    input  logic                           i_q_full,
    output logic                           o_push,
    output trk_pkg::t_seg_cmd              o_cmd
);
    import trk_pkg::*;

    logic                    r_have_prev;
    logic signed [LAT_W-1:0] r_prev_lat;
    logic signed [LON_W-1:0] r_prev_lon;
    logic [TIME_W-1:0]       r_prev_time;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_cmd.hp    = r_have_prev && !i_first_of_path;
        o_cmd.first = i_first_of_path;
        o_cmd.last  = i_last_of_path;
        o_cmd.lat1  = r_prev_lat;
        o_cmd.lat2  = i_latitude;
        o_cmd.dlat  = DLAT_W'(r_prev_lat) - DLAT_W'(i_latitude);
        o_cmd.dlon  = DLON_W'(r_prev_lon) - DLON_W'(i_longitude);
        o_cmd.gap   = (i_timestamp >= r_prev_time) ? (i_timestamp - r_prev_time)
                                                   : (r_prev_time - i_timestamp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (o_push) begin
            // the last point of a path leaves nothing behind
            r_have_prev <= !i_last_of_path;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_prev_lat  <= i_latitude;
            r_prev_lon  <= i_longitude;
            r_prev_time <= i_timestamp;
        end
    end

endmodule

// ===== sv/trk_queue.sv =====
// Short command queue between the front end and the distance engine.
// Depends on trk_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trk_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  trk_pkg::t_seg_cmd i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output trk_pkg::t_seg_cmd o_cmd
);
    import trk_pkg::*;

    t_seg_cmd            r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_cmd;
    end

    `CHK_ASSERT_CLK(a_no_push_full, i_push |-> !o_full)
    `CHK_ASSERT_CLK(a_no_pop_empty, i_pop |-> o_valid)

endmodule

// ===== sv/trk_back.sv =====
// Distance engine: haversine distance by shared CORDIC and square root, speed test,
// sticky path flag and output register. Depends on trk_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trk_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  trk_pkg::t_seg_cmd             i_cmd,
    output logic                          o_pop,
    input  logic [trk_pkg::SPEED_W-1:0]   i_speed_limit,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [trk_pkg::DIST_W-1:0]    o_segment_distance,
    output logic                          o_segment_too_fast,
    output logic                          o_path_suspect,
    output logic                          o_verdict_valid
);
    import trk_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_RED   = 5'd1;
    localparam logic [4:0] S_RAD   = 5'd2;
    localparam logic [4:0] S_ZLOAD = 5'd3;
    localparam logic [4:0] S_CORD  = 5'd4;
    localparam logic [4:0] S_STORE = 5'd5;
    localparam logic [4:0] S_M1    = 5'd6;
    localparam logic [4:0] S_M2    = 5'd7;
    localparam logic [4:0] S_M3    = 5'd8;
    localparam logic [4:0] S_M4    = 5'd9;
    localparam logic [4:0] S_M5    = 5'd10;
    localparam logic [4:0] S_M6    = 5'd11;
    localparam logic [4:0] S_SQRT  = 5'd12;
    localparam logic [4:0] S_VLOAD = 5'd13;
    localparam logic [4:0] S_D1    = 5'd14;
    localparam logic [4:0] S_D2    = 5'd15;
    localparam logic [4:0] S_F1    = 5'd16;
    localparam logic [4:0] S_F2    = 5'd17;
    localparam logic [4:0] S_OUT   = 5'd18;

    localparam logic [1:0] K_LAST = 2'd3;

    logic [4:0]              r_state;
    t_seg_cmd                r_cmd;
    logic [1:0]              r_k;
    logic                    r_neg;
    logic [ANG_W-1:0]        r_u;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_vec;
    logic signed [CW-1:0]    r_x, r_y, r_z;
    logic signed [CW-1:0]    r_sa, r_sb, r_c1, r_c2, r_cc;
    logic signed [MUL_W-1:0] r_p;
    logic [SQ_W-1:0]         r_n_a, r_n_b, r_res_a, r_res_b, r_bit;
    logic [DIST_W-1:0]       r_dist;
    logic                    r_fast;
    logic                    r_flag;
    logic                    r_out_valid;
    logic [DIST_W-1:0]       r_out_dist;
    logic                    r_out_fast, r_out_suspect, r_out_verdict;

    logic signed [CW-1:0]     mul_a, mul_b;
    logic signed [MUL_W-1:0]  prod;
    logic signed [DLON_W-1:0] ang_sel;
    t_red                     red;
    logic signed [CW-1:0]     dx, dy, at;
    logic                     pos;
    logic [SQ_W-1:0]          trial_a, trial_b;
    logic signed [MUL_W-Q_FRAC-1:0] hsum;
    logic [H_W-1:0]           h;
    logic [MUL_W-1:0]         rounded;
    logic [MUL_W-Q_FRAC-1:0]  dist_full;
    logic signed [CW-1:0]     zc;
    logic                     out_free;
    logic                     flag_now;

    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign out_free = !r_out_valid || !i_out_stall;
    assign flag_now = r_flag || r_fast;

    // angle selection and folding
    always_comb begin
        case (r_k)
            2'd0:    ang_sel = DLON_W'(r_cmd.dlat);
            2'd1:    ang_sel = r_cmd.dlon;
            2'd2:    ang_sel = DLON_W'(r_cmd.lat1);
            default: ang_sel = DLON_W'(r_cmd.lat2);
        endcase
        red = reduce_angle(ang_sel, r_k[1]);
    end

    // one shared multiplier
    assign zc = r_z[CW-1] ? '0 : r_z;
    always_comb begin
        case (r_state)
            S_RAD: begin
                mul_a = CW'({1'b0, r_u});
                mul_b = DEG2RAD_Q32;
            end
            S_M1: begin
                mul_a = r_sa;
                mul_b = r_sa;
            end
            S_M2: begin
                mul_a = r_sb;
                mul_b = r_sb;
            end
            S_M3: begin
                mul_a = r_c1;
                mul_b = r_c2;
            end
            S_M5: begin
                mul_a = r_cc;
                mul_b = r_sb;
            end
            S_D1: begin
                mul_a = zc;
                mul_b = TWO_RADIUS;
            end
            S_F1: begin
                mul_a = CW'({1'b0, i_speed_limit});
                mul_b = CW'({1'b0, r_cmd.gap});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // CORDIC step: rotation drives z to zero, vectoring drives y to zero
    assign dx  = r_y >>> r_cnt;
    assign dy  = r_x >>> r_cnt;
    assign at  = atan_q30(r_cnt);
    assign pos = r_vec ? r_y[CW-1] : !r_z[CW-1];

    // square root steps
    assign trial_a = r_res_a + r_bit;
    assign trial_b = r_res_b + r_bit;

    // h = sin^2(dlat/2) + cc * sin^2(dlon/2), clamped to [0, 1]
    always_comb begin
        hsum = (MUL_W-Q_FRAC)'(r_sa) + r_p[MUL_W-1:Q_FRAC];
        if (hsum[MUL_W-Q_FRAC-1])                      h = '0;
        else if (hsum > (MUL_W-Q_FRAC)'(Q30_ONE))      h = Q30_ONE;
        else                                           h = hsum[H_W-1:0];
    end

    assign rounded   = MUL_W'(r_p) + ROUND_HALF;
    assign dist_full = rounded[MUL_W-1:Q_FRAC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // load a new item or drop the one just taken
            if ((r_state == S_OUT) && out_free) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_cmd.first) r_flag <= 1'b0;
                        r_state <= i_cmd.hp ? S_RED : S_OUT;
                    end
                end
                S_RED:   r_state <= S_RAD;
                S_RAD:   r_state <= S_ZLOAD;
                S_ZLOAD: r_state <= S_CORD;
                S_CORD: begin
                    if (r_cnt == CNT_W'(CORDIC_ITERS - 1))
                        r_state <= r_vec ? S_D1 : S_STORE;
                end
                S_STORE: r_state <= (r_k == K_LAST) ? S_M1 : S_RED;
                S_M1:    r_state <= S_M2;
                S_M2:    r_state <= S_M3;
                S_M3:    r_state <= S_M4;
                S_M4:    r_state <= S_M5;
                S_M5:    r_state <= S_M6;
                S_M6:    r_state <= S_SQRT;
                S_SQRT: begin
                    if (r_cnt == CNT_W'(SQRT_STEPS - 1)) r_state <= S_VLOAD;
                end
                S_VLOAD: r_state <= S_CORD;
                S_D1:    r_state <= S_D2;
                S_D2:    r_state <= S_F1;
                S_F1:    r_state <= S_F2;
                S_F2:    r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_flag      <= r_cmd.last ? 1'b0 : flag_now;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd  <= i_cmd;
                r_k    <= '0;
                r_dist <= '0;
                r_fast <= 1'b0;
            end
            S_RED: begin
                r_u   <= red.u;
                r_neg <= red.neg;
            end
            S_RAD: r_p <= prod;
            S_ZLOAD: begin
                r_x   <= GAIN_INV;
                r_y   <= '0;
                r_z   <= r_k[1] ? CW'(r_p >>> (ANGLE_FRAC_BITS + 2))
                                : CW'(r_p >>> (ANGLE_FRAC_BITS + 3));
                r_vec <= 1'b0;
                r_cnt <= '0;
            end
            S_CORD: begin
                if (pos) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + at;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            S_STORE: begin
                case (r_k)
                    2'd0:    r_sa <= r_y;
                    2'd1:    r_sb <= r_y;
                    2'd2:    r_c1 <= r_neg ? -r_x : r_x;
                    default: r_c2 <= r_neg ? -r_x : r_x;
                endcase
                r_k <= r_k + 1'b1;
            end
            S_M1: r_p <= prod;
            S_M2: begin
                r_sa <= CW'(r_p >>> Q_FRAC);
                r_p  <= prod;
            end
            S_M3: begin
                r_sb <= CW'(r_p >>> Q_FRAC);
                r_p  <= prod;
            end
            S_M4: r_cc <= CW'(r_p >>> Q_FRAC);
            S_M5: r_p <= prod;
            S_M6: begin
                r_n_a   <= SQ_W'({h, {Q_FRAC{1'b0}}});
                r_n_b   <= SQ_W'({Q30_ONE - h, {Q_FRAC{1'b0}}});
                r_res_a <= '0;
                r_res_b <= '0;
                r_bit   <= SQ_BIT0;
                r_cnt   <= '0;
            end
            S_SQRT: begin
                if (r_n_a >= trial_a) begin
                    r_n_a   <= r_n_a - trial_a;
                    r_res_a <= (r_res_a >> 1) + r_bit;
                end else begin
                    r_res_a <= r_res_a >> 1;
                end
                if (r_n_b >= trial_b) begin
                    r_n_b   <= r_n_b - trial_b;
                    r_res_b <= (r_res_b >> 1) + r_bit;
                end else begin
                    r_res_b <= r_res_b >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
            end
            S_VLOAD: begin
                r_x   <= CW'({1'b0, r_res_b[H_W-1:0]});
                r_y   <= CW'({1'b0, r_res_a[H_W-1:0]});
                r_z   <= '0;
                r_vec <= 1'b1;
                r_cnt <= '0;
            end
            S_D1: r_p <= prod;
            S_D2: begin
                r_dist <= (dist_full[MUL_W-Q_FRAC-1:DIST_W] != '0) ? DIST_MAX
                                                                   : dist_full[DIST_W-1:0];
            end
            S_F1: r_p <= prod;
            S_F2: r_fast <= (64'({r_dist, 16'b0}) > 64'(r_p[63:0]));
            S_OUT: begin
                if (out_free) begin
                    r_out_dist    <= r_dist;
                    r_out_fast    <= r_fast;
                    r_out_suspect <= flag_now;
                    r_out_verdict <= r_cmd.last;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid        = r_out_valid;
    assign o_segment_distance = r_out_dist;
    assign o_segment_too_fast = r_out_fast;
    assign o_path_suspect     = r_out_suspect;
    assign o_verdict_valid    = r_out_verdict;

    `CHK_ASSERT_CLK(a_cord_bound, (r_state == S_CORD) |-> (r_cnt < CNT_W'(CORDIC_ITERS)))
    `CHK_ASSERT_CLK(a_no_prev_zero, (r_state == S_OUT && !r_cmd.hp) |-> (r_dist == '0 && !r_fast))
    `CHK_ASSERT_CLK(a_out_hold, (r_state == S_OUT && r_out_valid && i_out_stall) |=> r_out_valid)

endmodule

// ===== tb/tb_track_speed_plausibility_check_unit.sv =====
// Self-checking testbench for track_speed_plausibility_check_unit: directed and random
// paths, a fixed-point haversine predictor and an in-order result scoreboard.
// Depends on trk_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_track_speed_plausibility_check_unit;
    import trk_pkg::*;

    localparam longint unsigned TURN_FULL = 64'd360 << 20;
    localparam longint unsigned TURN_HALF = 64'd180 << 20;
    localparam longint unsigned TURN_QTR  = 64'd90 << 20;
    localparam longint          RAD_Q32   = 74961321;
    localparam longint          GAIN_Q30  = 652032874;
    localparam longint          ONE_Q30   = 64'sd1 << 30;
    localparam longint unsigned DIST_SAT  = 64'd33554431;
    localparam int              CYCLE_LIMIT = 3000000;
    localparam longint ATAN_TBL [30] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002
    };

    typedef struct {
        logic [DIST_W-1:0] seg_dist;
        logic              fast;
        logic              suspect;
        logic              verdict;
    } t_seg_result;

    class segment_scoreboard;
        logic [SPEED_W-1:0] speed_limit = SPEED_RESET;
        longint             prev_lat, prev_lon;
        logic [TIME_W-1:0]  prev_t;
        bit                 have_prev, suspect;
        t_seg_result        pending [$];
        int                 errors;

        function void rotate(input longint theta, output longint c, output longint s);
            longint x, y, z, dx, dy;
            x = GAIN_Q30; y = 0; z = theta;
            for (int i = 0; i < 30; i++) begin
                dx = y >>> i; dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= ATAN_TBL[i];
                end else begin
                    x += dx; y -= dy; z += ATAN_TBL[i];
                end
            end
            c = x; s = y;
        endfunction

        function longint vector_angle(input longint y, input longint x);
            longint z, dx, dy;
            z = 0;
            for (int i = 0; i < 30; i++) begin
                dx = y >>> i; dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += ATAN_TBL[i];
                end else begin
                    x -= dx; y += dy; z -= ATAN_TBL[i];
                end
            end
            return z;
        endfunction

        function longint unsigned int_sqrt(input longint unsigned n);
            longint unsigned res, bitv;
            res = 0; bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n -= res + bitv; res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function longint cos_of(input longint a);
            longint unsigned u;
            longint c, s;
            bit neg;
            neg = 0;
            u = longint'(a < 0 ? -a : a) % TURN_FULL;
            if (u > TURN_HALF) u = TURN_FULL - u;
            if (u > TURN_QTR) begin
                u = TURN_HALF - u; neg = 1;
            end
            rotate(longint'((u * RAD_Q32) >> 22), c, s);
            return neg ? -c : c;
        endfunction

        function longint half_sin_sq(input longint d);
            longint unsigned u;
            longint c, s;
            u = longint'(d < 0 ? -d : d) % TURN_FULL;
            if (u > TURN_HALF) u = TURN_FULL - u;
            rotate(longint'((u * RAD_Q32) >> 23), c, s);
            return (s * s) >>> 30;
        endfunction

        function longint unsigned great_circle_m(input longint la1, input longint lo1,
                                                 input longint la2, input longint lo2);
            longint sa, sb, cc, h, z;
            longint unsigned d;
            sa = half_sin_sq(la1 - la2);
            sb = half_sin_sq(lo1 - lo2);
            cc = (cos_of(la1) * cos_of(la2)) >>> 30;
            h = sa + ((cc * sb) >>> 30);
            if (h < 0) h = 0;
            if (h > ONE_Q30) h = ONE_Q30;
            z = vector_angle(longint'(int_sqrt(longint'(h) << 30)),
                             longint'(int_sqrt(longint'(ONE_Q30 - h) << 30)));
            if (z < 0) z = 0;
            d = (64'd12742000 * longint'(z) + (64'd1 << 29)) >> 30;
            return d > DIST_SAT ? DIST_SAT : d;
        endfunction

        function void note_point(input logic signed [LAT_W-1:0] lat,
                                 input logic signed [LON_W-1:0] lon,
                                 input logic [TIME_W-1:0] t, input bit first, input bit last);
            t_seg_result r;
            longint unsigned gap;
            r.seg_dist = '0; r.fast = 0;
            if (first) begin
                have_prev = 0; suspect = 0;
            end
            if (have_prev) begin
                gap = (t >= prev_t) ? longint'(t - prev_t) : longint'(prev_t - t);
                r.seg_dist = DIST_W'(great_circle_m(prev_lat, prev_lon, lat, lon));
                r.fast = (longint'(r.seg_dist) << 16) > longint'(speed_limit) * gap;
                if (r.fast) suspect = 1;
            end
            prev_lat = lat; prev_lon = lon; prev_t = t; have_prev = 1;
            r.suspect = suspect;
            r.verdict = last;
            if (last) begin
                have_prev = 0; suspect = 0;
            end
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(input t_seg_result got);
            t_seg_result exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result dist=%0d", $time, got.seg_dist);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.seg_dist !== exp_r.seg_dist) begin
                $display("%0t: distance exp %0d got %0d", $time, exp_r.seg_dist, got.seg_dist);
                errors++;
            end
            if (got.fast !== exp_r.fast) begin
                $display("%0t: too_fast exp %0b got %0b", $time, exp_r.fast, got.fast);
                errors++;
            end
            if (got.suspect !== exp_r.suspect) begin
                $display("%0t: suspect exp %0b got %0b", $time, exp_r.suspect, got.suspect);
                errors++;
            end
            if (got.verdict !== exp_r.verdict) begin
                $display("%0t: verdict exp %0b got %0b", $time, exp_r.verdict, got.verdict);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk = 0, i_rst_n = 0;
    logic                     i_in_valid = 0, o_in_stall;
    logic signed [LAT_W-1:0]  i_latitude = '0;
    logic signed [LON_W-1:0]  i_longitude = '0;
    logic [TIME_W-1:0]        i_timestamp = '0;
    logic                     i_first_of_path = 0, i_last_of_path = 0;
    logic                     o_out_valid, i_out_stall = 0;
    logic [DIST_W-1:0]        o_segment_distance;
    logic                     o_segment_too_fast, o_path_suspect, o_verdict_valid;
    logic                     i_cfg_valid = 0, o_cfg_ready;
    logic [SPEED_W-1:0]       i_cfg_data = '0;

    track_speed_plausibility_check_unit i_dut (.*);

    segment_scoreboard sb = new();
    int     send_idle_pct = 0, recv_idle_pct = 0;
    int     cycles = 0;
    logic [TIME_W-1:0] clock_s = 32'd1000;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("track_speed_plausibility_check_unit: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_seg_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.seg_dist = o_segment_distance; got.fast = o_segment_too_fast;
            got.suspect = o_path_suspect; got.verdict = o_verdict_valid;
            sb.check_result(got);
        end
    end

    always @(negedge i_clk)
        i_out_stall = ($urandom_range(99) < recv_idle_pct);

    task automatic send_point(input logic signed [LAT_W-1:0] lat,
                              input logic signed [LON_W-1:0] lon,
                              input logic [TIME_W-1:0] t, input bit first, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 0;
            @(negedge i_clk);
        end
        i_in_valid = 1; i_latitude = lat; i_longitude = lon; i_timestamp = t;
        i_first_of_path = first; i_last_of_path = last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_point(lat, lon, t, first, last);
        @(negedge i_clk);
        i_in_valid = 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [SPEED_W-1:0] v);
        drain();
        i_cfg_valid = 1; i_cfg_data = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.speed_limit = v;
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    // Random path: well-formed mostly, with noisy marks and raw full-width angles.
    task automatic random_path(inout int budget);
        int len, lat0, lon0, step;
        bit noisy;
        logic signed [LAT_W-1:0] la;
        logic signed [LON_W-1:0] lo;
        len = $urandom_range(1, 8);
        noisy = ($urandom_range(9) == 0);
        lat0 = int'($urandom_range(188743680)) - 94371840;
        lon0 = int'($urandom_range(377487360)) - 188743680;
        step = ($urandom_range(3) == 0) ? (1 << $urandom_range(24)) : (1 << 14);
        for (int k = 0; k < len && budget > 0; k++) begin
            la = LAT_W'(lat0); lo = LON_W'(lon0);
            if (noisy && $urandom_range(2) == 0) begin
                la = $urandom(); lo = $urandom();
            end
            case ($urandom_range(9))
                0:       clock_s = clock_s;
                1:       clock_s = clock_s - $urandom_range(30);
                2:       clock_s = $urandom();
                default: clock_s = clock_s + $urandom_range(1, 90);
            endcase
            if (noisy)
                send_point(la, lo, clock_s, $urandom_range(1), $urandom_range(1));
            else
                send_point(la, lo, clock_s, k == 0, k == len - 1);
            budget--;
            lat0 += int'($urandom_range(2 * step)) - step;
            lon0 += int'($urandom_range(2 * step)) - step;
        end
    endtask

    initial begin
        logic [SPEED_W-1:0] limits [6];
        int budget;
        limits = '{32'd0, 32'hFFFF_FFFF, 32'd13107200, 32'd1966080, 32'd0, 32'd1};
        limits[4] = $urandom();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed: single point, equal times, extremes, wrap-around, reversed time.
        send_point(0, 0, 0, 1, 1);
        send_point(1000, 1000, 100, 1, 0);
        send_point(1000, 1000, 100, 0, 0);
        send_point(2000, 1000, 100, 0, 0);
        send_point(2000, 5000, 50, 0, 1);
        send_point(94371840, 188743680, 0, 1, 0);
        send_point(-94371840, -188743680, 32'hFFFF_FFFF, 0, 0);
        send_point(0, 188743680, 32'hFFFF_FFFF, 0, 0);
        send_point(0, -188743680, 32'h0, 0, 1);
        send_point(-28'sd134217728, -29'sd268435456, 7, 1, 0);
        send_point(28'sd134217727, 29'sd268435455, 9, 0, 0);
        send_point(94371840, 0, 10, 0, 0);
        send_point(-94371840, 0, 11, 0, 1);
        send_point(5000, 5000, 20, 0, 0);
        send_point(5100, 5000, 40, 0, 0);
        send_point(5200, 5000, 60, 1, 1);
        send_point(1 << 20, 1 << 20, 1, 1, 0);
        send_point(1 << 20, (1 << 20) + 1, 100000, 0, 1);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin send_idle_pct = 6;  recv_idle_pct = 50; end
                1: begin send_idle_pct = 50; recv_idle_pct = 6;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            write_limit(limits[ph]);
            budget = 305;
            while (budget > 0) random_path(budget);
        end

        drain();
        repeat (250) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("track_speed_plausibility_check_unit: match");
        else
            $display("track_speed_plausibility_check_unit: mismatch");
        $finish;
    end
endmodule
